[hdl/ifla_pkg.sv]
`timescale 1ns / 1ps

package ifla_pkg;

  localparam int POOL_SIZE = 256;
  localparam int ADDR_W    = $clog2(POOL_SIZE);
  localparam int LINK_W    = $clog2(POOL_SIZE + 1);
  localparam int FIELD_W   = 8;

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_SIZE);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } mem_req_t;

endpackage

[hdl/ifla_link_mem.sv]
`timescale 1ns / 1ps

module ifla_link_mem (
  input  logic                     clk,
  input  logic                     rst,
  input  ifla_pkg::mem_req_t       req,
  output logic [ifla_pkg::LINK_W-1:0] rdata
);

  logic [ifla_pkg::LINK_W-1:0] mem [ifla_pkg::POOL_SIZE];
  logic [ifla_pkg::POOL_SIZE-1:0] vld;
  logic [ifla_pkg::LINK_W-1:0] rd_q;
  logic [ifla_pkg::LINK_W-1:0] rd_dflt;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_q    <= mem[req.addr];
      rd_dflt <= ifla_pkg::LINK_W'(req.addr) + ifla_pkg::LINK_W'(1);
    end
  end

  // Never-written entries read as their reset link, i+1.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.addr];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : rd_dflt;

endmodule

[hdl/ifla_ctrl.sv]
`timescale 1ns / 1ps

module ifla_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  ifla_pkg::cmd_t                req_cmd,
  input  logic [ifla_pkg::FIELD_W-1:0]  req_index,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [ifla_pkg::FIELD_W-1:0]  rsp_granted,
  output logic                          rsp_ok,
  output logic                          rsp_empty,
  output ifla_pkg::mem_req_t            mem_req,
  input  logic [ifla_pkg::LINK_W-1:0]   mem_rdata
);

  ifla_pkg::state_t            state, state_next;
  logic [ifla_pkg::LINK_W-1:0] head, head_next;
  logic                        out_load;
  logic [ifla_pkg::FIELD_W-1:0] granted_next;
  logic                        ok_next;
  logic                        empty_next;
  logic                        accept;
  logic                        head_has;
  logic                        idx_in_range;

  assign accept       = req_valid && req_ready;
  assign head_has     = head < ifla_pkg::END_MARK;
  assign idx_in_range = 32'(req_index) < ifla_pkg::POOL_SIZE;

  always_comb begin
    state_next    = state;
    head_next     = head;
    out_load      = 1'b0;
    granted_next  = '0;
    ok_next       = 1'b0;
    empty_next    = !head_has;
    req_ready     = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = ifla_pkg::ADDR_W'(head);
    mem_req.wdata = head;
    unique case (state)
      ifla_pkg::ST_IDLE: begin
        req_ready = !rsp_valid || rsp_ready;
        if (accept) begin
          if (req_cmd == ifla_pkg::CMD_ALLOC) begin
            if (head_has) begin
              // fetch the link behind the head; ST_POP answers with it
              mem_req.rd_en = 1'b1;
              state_next    = ifla_pkg::ST_POP;
            end else begin
              out_load = 1'b1;
            end
          end else begin
            out_load = 1'b1;
            if (idx_in_range) begin
              mem_req.wr_en = 1'b1;
              mem_req.addr  = ifla_pkg::ADDR_W'(req_index);
              head_next     = ifla_pkg::LINK_W'(req_index);
              ok_next       = 1'b1;
              empty_next    = 1'b0;
            end
          end
        end
      end
      ifla_pkg::ST_POP: begin
        out_load     = 1'b1;
        head_next    = mem_rdata;
        granted_next = ifla_pkg::FIELD_W'(head);
        ok_next      = 1'b1;
        empty_next   = mem_rdata >= ifla_pkg::END_MARK;
        state_next   = ifla_pkg::ST_IDLE;
      end
      default: state_next = ifla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ifla_pkg::ST_IDLE;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      rsp_valid <= out_load || (rsp_valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_granted <= granted_next;
      rsp_ok      <= ok_next;
      rsp_empty   <= empty_next;
    end
  end

endmodule

[hdl/index_free_list_allocator_unit.sv]
`timescale 1ns / 1ps
// Response: a free or a failed allocate answers in the cycle after its request;
//   a successful allocate answers after one read of the link memory.
// Requests: none is taken during the link memory read or while a response is held.
// Reset: synchronous; the list head returns to index 0 and all link entries
//   read as the chain 0,1,...,last at once, with no clearing pass.
module index_free_list_allocator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] index
  input  logic       s_tuser,   // [0] cmd
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] granted_index
  output logic [1:0] m_tuser    // [0] ok, [1] pool_empty
);

  ifla_pkg::mem_req_t          mem_req;
  logic [ifla_pkg::LINK_W-1:0] mem_rdata;

  ifla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .req_cmd     (ifla_pkg::cmd_t'(s_tuser)),
    .req_index   (s_tdata),
    .rsp_valid   (m_tvalid),
    .rsp_ready   (m_tready),
    .rsp_granted (m_tdata),
    .rsp_ok      (m_tuser[0]),
    .rsp_empty   (m_tuser[1]),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  ifla_link_mem u_link_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  a_no_rd_wr_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("link memory read and write in the same cycle");

  a_free_answers_next: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == ifla_pkg::CMD_FREE) |=> m_tvalid)
    else $error("free request not answered in the next cycle");

  a_fail_grants_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("failed request carries a nonzero index");

  a_read_only_on_alloc: assert property (@(posedge clk) disable iff (rst)
    mem_req.rd_en |-> (s_tvalid && s_tready && s_tuser == ifla_pkg::CMD_ALLOC))
    else $error("link memory read without an allocate request");

endmodule
